// ===== hw/rtl/stmfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stmfe_pkg;

	localparam int KEY_MAX = 16;
	localparam int KEY_LEN_W = 5;

	localparam logic [2:0] ST_PARSING     = 3'd0;
	localparam logic [2:0] ST_FOUND       = 3'd1;
	localparam logic [2:0] ST_BAD_MARKER  = 3'd2;
	localparam logic [2:0] ST_BAD_NAMELEN = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
	localparam logic [2:0] ST_BAD_TYPE    = 3'd5;

	localparam logic [7:0] AMF_DOUBLE   = 8'h00;
	localparam logic [7:0] AMF_INT8     = 8'h01;
	localparam logic [7:0] AMF_STRING   = 8'h02;
	localparam logic [7:0] AMF_INT16    = 8'h03;
	localparam logic [7:0] AMF_LSTRING  = 8'h0C;

	localparam logic [7:0]  HDR_MARKER   = 8'h02;
	localparam logic [15:0] HDR_NAME_LEN = 16'd10;

	localparam logic [2:0] REG_MODE       = 3'd0;
	localparam logic [2:0] REG_KEY_LOW    = 3'd1;
	localparam logic [2:0] REG_KEY_HIGH   = 3'd2;
	localparam logic [2:0] REG_KEY_LENGTH = 3'd3;
	localparam logic [2:0] REG_NEW_VALUE  = 3'd4;

	// control from the parser to the name matcher
	typedef struct packed {
		logic clear;
		logic start;
		logic push;
	} name_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stmfe_name_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stmfe_name_match
	import stmfe_pkg::*;
#(
	parameter int KEY_BYTES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire name_ctl_t            ctl,
	input  wire logic [7:0]           name_byte,
	input  wire logic [63:0]          key_low,
	input  wire logic [63:0]          key_high,
	input  wire logic [KEY_LEN_W-1:0] key_length,
	output logic                      matched
);

	localparam int WIN = (KEY_BYTES < KEY_MAX) ? KEY_BYTES : KEY_MAX;
	localparam int CW = $clog2(WIN + 1);

	logic [7:0]           window_q [WIN];
	logic [7:0]           window_n [WIN];
	logic [CW-1:0]        seen_q;
	logic [CW-1:0]        seen_n;
	logic                 matched_q;
	logic [KEY_LEN_W-1:0] eff_len;
	logic [7:0]           key_b [KEY_MAX];
	logic                 hit;

	always_comb begin
		if (key_length > KEY_LEN_W'(WIN)) begin
			eff_len = KEY_LEN_W'(WIN);
		end else begin
			eff_len = key_length;
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			key_b[k]     = key_low[8*k +: 8];
			key_b[k + 8] = key_high[8*k +: 8];
		end
	end

	always_comb begin
		for (int i = 0; i < WIN - 1; i++) begin
			window_n[i] = window_q[i + 1];
		end
		window_n[WIN-1] = name_byte;
		if (seen_q == CW'(WIN)) begin
			seen_n = seen_q;
		end else begin
			seen_n = seen_q + CW'(1);
		end
	end

	// key as a suffix of the shifted window, for the active key length
	always_comb begin
		logic ok;
		hit = 1'b1;
		for (int l = 1; l <= WIN; l++) begin
			ok = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (window_n[WIN - l + k] != key_b[k]) begin
					ok = 1'b0;
				end
			end
			if (eff_len == KEY_LEN_W'(l)) begin
				hit = ok;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			matched_q <= 1'b0;
			for (int i = 0; i < WIN; i++) begin
				window_q[i] <= '0;
			end
		end else if (ctl.clear || ctl.start) begin
			seen_q    <= '0;
			matched_q <= ctl.start && (eff_len == '0);
			for (int i = 0; i < WIN; i++) begin
				window_q[i] <= '0;
			end
		end else if (ctl.push) begin
			seen_q   <= seen_n;
			window_q <= window_n;
			if (KEY_LEN_W'(seen_n) >= eff_len && hit) begin
				matched_q <= 1'b1;
			end
		end
	end

	assign matched = matched_q;

endmodule
`default_nettype wire

// ===== hw/rtl/script_tag_metadata_field_editor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Script tag metadata editor: parses the AMF0 ECMA array of a script tag body
// one byte per word and looks for the entry whose name contains the key.
// s_axis: tdata = body byte, tuser = first byte of a new tag body.
// m_axis: one word per input byte: the byte passed on (replaced by new_value,
// big-endian, over the matching double in set mode), the status, the matched
// raw value, a double flag and a finished flag.
// cfg: write channel, always ready; registers 0..4 = mode, key_low, key_high,
// key_length, new_value. Write only while no byte is in flight.
// Each accepted byte's result word is written straight into the output register.
// Throughput: one byte per cycle while m_axis does not stall; the parser step
// is a single state update between the accepted byte and the output register.
// Reset clears the parser and all registers; tuser = 1 restarts the parser.
// When m_axis stalls the output register holds its word and s_axis_tready
// drops; a word is accepted in the same cycle the waiting one is taken.
module script_tag_metadata_field_editor
	import stmfe_pkg::*;
#(
	parameter int KEY_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tuser,  // tag_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_byte[7:0], status[10:8], value_bits[74:11], value_is_double[75],
	// finished[76], zero[79:77]
	output logic [79:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	typedef enum logic [3:0] {
		PH_MARKER, PH_HDR_LEN, PH_HDR_NAME, PH_ARR_MARK, PH_COUNT, PH_ENT_LEN,
		PH_ENT_NAME, PH_TYPE, PH_VALUE, PH_STR_LEN, PH_STR_BODY
	} phase_t;

	logic                 mode_q;
	logic [63:0]          key_low_q;
	logic [63:0]          key_high_q;
	logic [KEY_LEN_W-1:0] key_length_q;
	logic [63:0]          new_value_q;

	phase_t      phase_q, phase_n, phase_c;
	logic [31:0] bytes_left_q, bytes_left_n, bytes_left_c;
	logic [31:0] entries_q, entries_n, entries_c;
	logic [7:0]  vtype_q, vtype_n, vtype_c;
	logic [63:0] acc_q, acc_n, acc_c;
	logic        stopped_q, stopped_n, stopped_c;
	logic [2:0]  fstat_q, fstat_n, fstat_c;

	logic        out_valid_q;
	logic [79:0] out_data_q;
	logic [79:0] out_data_n;

	logic        accept;
	logic [7:0]  b;
	logic [7:0]  ob;
	logic [31:0] bl_dec;
	logic [31:0] ent_dec;
	logic [63:0] acc_sh;
	logic        matched;
	logic        found;
	name_ctl_t   nctl;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			key_low_q    <= '0;
			key_high_q   <= '0;
			key_length_q <= '0;
			new_value_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:       mode_q       <= cfg_data[0];
				REG_KEY_LOW:    key_low_q    <= cfg_data;
				REG_KEY_HIGH:   key_high_q   <= cfg_data;
				REG_KEY_LENGTH: key_length_q <= cfg_data[KEY_LEN_W-1:0];
				REG_NEW_VALUE:  new_value_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// state seen by this byte, after a possible restart
	always_comb begin
		if (s_axis_tuser) begin
			phase_c      = PH_MARKER;
			bytes_left_c = '0;
			entries_c    = '0;
			vtype_c      = '0;
			acc_c        = '0;
			stopped_c    = 1'b0;
			fstat_c      = ST_PARSING;
		end else begin
			phase_c      = phase_q;
			bytes_left_c = bytes_left_q;
			entries_c    = entries_q;
			vtype_c      = vtype_q;
			acc_c        = acc_q;
			stopped_c    = stopped_q;
			fstat_c      = fstat_q;
		end
	end

	assign bl_dec  = bytes_left_c - 32'd1;
	assign ent_dec = entries_c - 32'd1;
	assign acc_sh  = {acc_c[55:0], b};

	always_comb begin
		phase_n      = phase_c;
		bytes_left_n = bytes_left_c;
		entries_n    = entries_c;
		vtype_n      = vtype_c;
		acc_n        = acc_c;
		stopped_n    = stopped_c;
		fstat_n      = fstat_c;
		ob           = b;
		nctl.clear   = accept && s_axis_tuser;
		nctl.start   = 1'b0;
		nctl.push    = 1'b0;

		if (!stopped_c) begin
			case (phase_c)
				PH_MARKER: begin
					if (b != HDR_MARKER) begin
						stopped_n = 1'b1;
						fstat_n   = ST_BAD_MARKER;
					end else begin
						phase_n      = PH_HDR_LEN;
						bytes_left_n = 32'd2;
						acc_n        = '0;
					end
				end
				PH_HDR_LEN: begin
					acc_n        = acc_sh;
					bytes_left_n = bl_dec;
					if (bl_dec == '0) begin
						if (acc_sh[15:0] != HDR_NAME_LEN) begin
							stopped_n = 1'b1;
							fstat_n   = ST_BAD_NAMELEN;
						end else begin
							phase_n      = PH_HDR_NAME;
							bytes_left_n = {16'd0, HDR_NAME_LEN};
						end
					end
				end
				PH_HDR_NAME: begin
					bytes_left_n = bl_dec;
					if (bl_dec == '0) begin
						phase_n = PH_ARR_MARK;
					end
				end
				PH_ARR_MARK: begin
					phase_n      = PH_COUNT;
					bytes_left_n = 32'd4;
					acc_n        = '0;
				end
				PH_COUNT: begin
					acc_n        = acc_sh;
					bytes_left_n = bl_dec;
					if (bl_dec == '0) begin
						entries_n = acc_sh[31:0];
						if (acc_sh[31:0] == '0) begin
							stopped_n = 1'b1;
							fstat_n   = ST_NOT_FOUND;
						end else begin
							phase_n      = PH_ENT_LEN;
							bytes_left_n = 32'd2;
							acc_n        = '0;
						end
					end
				end
				PH_ENT_LEN: begin
					acc_n        = acc_sh;
					bytes_left_n = bl_dec;
					if (bl_dec == '0) begin
						nctl.start = accept;
						if (acc_sh[15:0] == '0) begin
							phase_n = PH_TYPE;
						end else begin
							phase_n      = PH_ENT_NAME;
							bytes_left_n = {16'd0, acc_sh[15:0]};
						end
					end
				end
				PH_ENT_NAME: begin
					nctl.push    = accept;
					bytes_left_n = bl_dec;
					if (bl_dec == '0) begin
						phase_n = PH_TYPE;
					end
				end
				PH_TYPE: begin
					vtype_n = b;
					acc_n   = '0;
					case (b)
						AMF_DOUBLE: begin
							phase_n      = PH_VALUE;
							bytes_left_n = 32'd8;
						end
						AMF_INT8: begin
							phase_n      = PH_VALUE;
							bytes_left_n = 32'd1;
						end
						AMF_INT16: begin
							phase_n      = PH_VALUE;
							bytes_left_n = 32'd2;
						end
						AMF_STRING: begin
							phase_n      = PH_STR_LEN;
							bytes_left_n = 32'd2;
						end
						AMF_LSTRING: begin
							phase_n      = PH_STR_LEN;
							bytes_left_n = 32'd4;
						end
						default: begin
							stopped_n = 1'b1;
							fstat_n   = ST_BAD_TYPE;
						end
					endcase
				end
				PH_VALUE: begin
					if (mode_q && matched && vtype_c == AMF_DOUBLE) begin
						ob = new_value_q[8*bl_dec[2:0] +: 8];
					end
					acc_n        = acc_sh;
					bytes_left_n = bl_dec;
					if (bl_dec == '0) begin
						if (matched && (!mode_q || vtype_c == AMF_DOUBLE)) begin
							stopped_n = 1'b1;
							fstat_n   = ST_FOUND;
						end else begin
							entries_n = ent_dec;
							if (ent_dec == '0) begin
								stopped_n = 1'b1;
								fstat_n   = ST_NOT_FOUND;
							end else begin
								phase_n      = PH_ENT_LEN;
								bytes_left_n = 32'd2;
								acc_n        = '0;
							end
						end
					end
				end
				PH_STR_LEN: begin
					acc_n        = acc_sh;
					bytes_left_n = bl_dec;
					if (bl_dec == '0) begin
						if (acc_sh[31:0] == '0) begin
							entries_n = ent_dec;
							if (ent_dec == '0) begin
								stopped_n = 1'b1;
								fstat_n   = ST_NOT_FOUND;
							end else begin
								phase_n      = PH_ENT_LEN;
								bytes_left_n = 32'd2;
								acc_n        = '0;
							end
						end else begin
							phase_n      = PH_STR_BODY;
							bytes_left_n = acc_sh[31:0];
						end
					end
				end
				PH_STR_BODY: begin
					bytes_left_n = bl_dec;
					if (bl_dec == '0) begin
						entries_n = ent_dec;
						if (ent_dec == '0) begin
							stopped_n = 1'b1;
							fstat_n   = ST_NOT_FOUND;
						end else begin
							phase_n      = PH_ENT_LEN;
							bytes_left_n = 32'd2;
							acc_n        = '0;
						end
					end
				end
				default: begin
					stopped_n = 1'b1;
					fstat_n   = ST_NOT_FOUND;
				end
			endcase
		end
	end

	assign found = stopped_n && (fstat_n == ST_FOUND);

	always_comb begin
		out_data_n        = '0;
		out_data_n[7:0]   = ob;
		out_data_n[10:8]  = stopped_n ? fstat_n : ST_PARSING;
		out_data_n[74:11] = found ? acc_n : 64'd0;
		out_data_n[75]    = found && (vtype_n == AMF_DOUBLE);
		out_data_n[76]    = stopped_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MARKER;
			bytes_left_q <= '0;
			entries_q    <= '0;
			vtype_q      <= '0;
			acc_q        <= '0;
			stopped_q    <= 1'b0;
			fstat_q      <= ST_PARSING;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (accept) begin
				phase_q      <= phase_n;
				bytes_left_q <= bytes_left_n;
				entries_q    <= entries_n;
				vtype_q      <= vtype_n;
				acc_q        <= acc_n;
				stopped_q    <= stopped_n;
				fstat_q      <= fstat_n;
				out_data_q   <= out_data_n;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	stmfe_name_match #(
		.KEY_BYTES(KEY_BYTES)
	) u_name_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (nctl),
		.name_byte  (b),
		.key_low    (key_low_q),
		.key_high   (key_high_q),
		.key_length (key_length_q),
		.matched    (matched)
	);

endmodule
`default_nettype wire
